### rtl/swhsr_pkg.sv
// Shared types and constants of the single-wire humidity sensor reader.
package swhsr_pkg;

    localparam int FRAME_BITS = 40;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_START_LOW     = 2'd0;
    localparam logic [1:0] REG_RELEASE       = 2'd1;
    localparam logic [1:0] REG_TIMEOUT       = 2'd2;
    localparam logic [1:0] REG_BIT_THRESHOLD = 2'd3;

    // Read status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START_LOW = 3'd1,
        PH_RELEASE   = 3'd2,
        PH_RESP_WAIT = 3'd3,
        PH_RESP_LOW  = 3'd4,
        PH_RESP_HIGH = 3'd5,
        PH_BIT_LOW   = 3'd6,
        PH_BIT_HIGH  = 3'd7
    } swhsr_phase_t;

    typedef enum logic {
        ITEM_TICK  = 1'b0,
        ITEM_START = 1'b1
    } swhsr_kind_t;

    typedef struct packed {
        swhsr_kind_t kind;
        logic        pin;
    } swhsr_item_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [15:0] timeout_ticks;
        logic [7:0]  bit_threshold_ticks;
    } swhsr_cfg_t;

    typedef struct packed {
        logic               drive_low;
        logic               busy;
        logic               done;
        logic [1:0]         status;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
    } swhsr_result_t;

endpackage

### rtl/swhsr_fifo.sv
// Small first-in first-out queue built from flip-flops.
module swhsr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### rtl/swhsr_front.sv
// Front end: classifies each incoming request and queues it for the protocol engine.
module swhsr_front #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  cmd,
    input  logic                  pin_level,
    output logic                  full,
    input  logic                  item_pop,
    output swhsr_pkg::swhsr_item_t item,
    output logic                  item_empty
);
    import swhsr_pkg::*;

    swhsr_item_t in_item;

    always_comb
    begin
        in_item.kind = cmd ? ITEM_START : ITEM_TICK;
        in_item.pin  = pin_level;
    end

    swhsr_fifo #(
        .WIDTH ($bits(swhsr_item_t)),
        .DEPTH (DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (in_item),
        .full  (full),
        .pop   (item_pop),
        .dout  (item),
        .empty (item_empty)
    );

endmodule

### rtl/swhsr_engine.sv
// Back end: line protocol state machine, pulse timing, frame decode and held readings.
module swhsr_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  swhsr_pkg::swhsr_cfg_t   cfg,
    input  swhsr_pkg::swhsr_item_t  item,
    input  logic                    item_valid,
    input  logic                    res_full,
    output logic                    item_pop,
    output logic                    res_push,
    output swhsr_pkg::swhsr_result_t res
);
    import swhsr_pkg::*;

    swhsr_phase_t phase_reg, phase_next;
    logic [15:0]  level_cnt_reg, level_cnt_next;
    logic [5:0]   bit_idx_reg, bit_idx_next;
    logic [39:0]  frame_reg, frame_next;
    logic [15:0]  hum_reg, hum_next;
    logic [15:0]  temp_reg, temp_next;

    logic        fire;
    logic        fail;
    logic        drive;
    logic        done;
    logic [1:0]  status_val;
    logic        sample_to;
    logic        fresh_to;
    logic [15:0] cnt_inc;
    logic        bit_val;
    logic [39:0] frame_shifted;
    logic [5:0]  bit_idx_inc;
    logic [7:0]  sum8;
    logic [15:0] raw_t;

    assign fire      = item_valid && !res_full;
    assign item_pop  = fire;
    assign res_push  = fire;
    assign sample_to = (level_cnt_reg >= cfg.timeout_ticks);
    assign fresh_to  = (cfg.timeout_ticks == 16'd0);
    assign cnt_inc   = level_cnt_reg + 16'd1;
    assign bit_val   = (level_cnt_reg > {8'd0, cfg.bit_threshold_ticks});
    assign frame_shifted = {frame_reg[38:0], bit_val};
    assign bit_idx_inc   = bit_idx_reg + 6'd1;
    assign sum8  = frame_shifted[39:32] + frame_shifted[31:24]
                 + frame_shifted[23:16] + frame_shifted[15:8];
    assign raw_t = frame_shifted[23:8];

    always_comb
    begin
        phase_next     = phase_reg;
        level_cnt_next = level_cnt_reg;
        bit_idx_next   = bit_idx_reg;
        frame_next     = frame_reg;
        hum_next       = hum_reg;
        temp_next      = temp_reg;
        drive          = 1'b0;
        done           = 1'b0;
        status_val     = ST_OK;
        fail           = 1'b0;

        if (fire)
        begin
            if (phase_reg == PH_IDLE && item.kind == ITEM_START)
            begin
                phase_next     = PH_START_LOW;
                level_cnt_next = '0;
                bit_idx_next   = '0;
                frame_next     = '0;
                drive          = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                    end
                    PH_START_LOW:
                    begin
                        drive = 1'b1;
                        if (cnt_inc >= cfg.start_low_ticks)
                        begin
                            phase_next     = PH_RELEASE;
                            level_cnt_next = '0;
                        end
                        else
                        begin
                            level_cnt_next = cnt_inc;
                        end
                    end
                    PH_RELEASE:
                    begin
                        if (cnt_inc >= {8'd0, cfg.release_ticks})
                        begin
                            phase_next     = PH_RESP_WAIT;
                            level_cnt_next = '0;
                        end
                        else
                        begin
                            level_cnt_next = cnt_inc;
                        end
                    end
                    PH_RESP_WAIT, PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW:
                    begin
                        // Odd phases of the response wait for a low level, the others for a high one.
                        if (item.pin == (phase_reg == PH_RESP_WAIT
                                         || phase_reg == PH_RESP_HIGH))
                        begin
                            fail           = sample_to;
                            level_cnt_next = cnt_inc;
                        end
                        else
                        begin
                            phase_next     = swhsr_phase_t'(phase_reg + 3'd1);
                            fail           = fresh_to;
                            level_cnt_next = 16'd1;
                        end
                    end
                    PH_BIT_HIGH:
                    begin
                        if (item.pin)
                        begin
                            fail           = sample_to;
                            level_cnt_next = cnt_inc;
                        end
                        else
                        begin
                            frame_next   = frame_shifted;
                            bit_idx_next = bit_idx_inc;
                            if (bit_idx_inc >= 6'(FRAME_BITS))
                            begin
                                done           = 1'b1;
                                phase_next     = PH_IDLE;
                                level_cnt_next = '0;
                                if (sum8 != frame_shifted[7:0])
                                begin
                                    status_val = ST_CHECKSUM;
                                end
                                else
                                begin
                                    hum_next = frame_shifted[39:24];
                                    // Sign-magnitude to two's complement; negative zero reads as zero.
                                    temp_next = raw_t[15] ? (16'd0 - {1'b0, raw_t[14:0]})
                                                          : raw_t;
                                end
                            end
                            else
                            begin
                                phase_next     = PH_BIT_LOW;
                                fail           = fresh_to;
                                level_cnt_next = 16'd1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (fail)
            begin
                status_val     = ST_TIMEOUT;
                done           = 1'b1;
                phase_next     = PH_IDLE;
                level_cnt_next = '0;
            end
        end

        res.drive_low   = drive;
        res.busy        = (phase_next != PH_IDLE);
        res.done        = done;
        res.status      = status_val;
        res.humidity    = hum_next;
        res.temperature = temp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            level_cnt_reg <= '0;
            bit_idx_reg   <= '0;
            frame_reg     <= '0;
            hum_reg       <= '0;
            temp_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            level_cnt_reg <= level_cnt_next;
            bit_idx_reg   <= bit_idx_next;
            frame_reg     <= frame_next;
            hum_reg       <= hum_next;
            temp_reg      <= temp_next;
        end
    end

endmodule

### rtl/single_wire_humidity_sensor_reader_unit.sv
// Single-wire humidity sensor reader: top level with configuration registers and result queue.
// Throughput: one request per clock; the engine retires one request per cycle unless res_full.
// A request waits in the input queue; its result is registered in the result queue.
// The input queue (ITEM_DEPTH) and result queue (RES_DEPTH) let either side stall alone.
// Reset clears the queues, the protocol state and the held readings, and loads register defaults.
module single_wire_humidity_sensor_reader_unit #(
    parameter int ITEM_DEPTH = 4,
    parameter int RES_DEPTH  = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    input  logic               cmd,
    input  logic               pin_level,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output logic               drive_low,
    output logic               busy_res,
    output logic               done_res,
    output logic [1:0]         status,
    output logic [15:0]        humidity,
    output logic signed [15:0] temperature
);
    import swhsr_pkg::*;

    swhsr_cfg_t    cfg_reg;
    swhsr_item_t   item;
    swhsr_result_t res_in;
    swhsr_result_t res_out;
    logic          item_empty;
    logic          item_pop;
    logic          res_push;
    logic          res_full;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks     <= 16'd2000;
            cfg_reg.release_ticks       <= 8'd30;
            cfg_reg.timeout_ticks       <= 16'd100;
            cfg_reg.bit_threshold_ticks <= 8'd50;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_START_LOW:     cfg_reg.start_low_ticks     <= pwdata[15:0];
                REG_RELEASE:       cfg_reg.release_ticks       <= pwdata[7:0];
                REG_TIMEOUT:       cfg_reg.timeout_ticks       <= pwdata[15:0];
                REG_BIT_THRESHOLD: cfg_reg.bit_threshold_ticks <= pwdata[7:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_START_LOW:     prdata = {16'd0, cfg_reg.start_low_ticks};
            REG_RELEASE:       prdata = {24'd0, cfg_reg.release_ticks};
            REG_TIMEOUT:       prdata = {16'd0, cfg_reg.timeout_ticks};
            REG_BIT_THRESHOLD: prdata = {24'd0, cfg_reg.bit_threshold_ticks};
            default:           prdata = '0;
        endcase
    end

    swhsr_front #(
        .DEPTH (ITEM_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .cmd        (cmd),
        .pin_level  (pin_level),
        .full       (full),
        .item_pop   (item_pop),
        .item       (item),
        .item_empty (item_empty)
    );

    swhsr_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (item),
        .item_valid (!item_empty),
        .res_full   (res_full),
        .item_pop   (item_pop),
        .res_push   (res_push),
        .res        (res_in)
    );

    swhsr_fifo #(
        .WIDTH ($bits(swhsr_result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign drive_low   = res_out.drive_low;
    assign busy_res    = res_out.busy;
    assign done_res    = res_out.done;
    assign status      = res_out.status;
    assign humidity    = res_out.humidity;
    assign temperature = res_out.temperature;

    // A finished read always leaves the block idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && done_res) |-> !busy_res)
        else $error("done result reports busy");

    // A nonzero status only comes with the end of a read.
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |-> done_res)
        else $error("status set without done");

    // The line is only pulled low while a read is under way.
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && drive_low) |-> busy_res)
        else $error("line driven while idle");

    // The engine never retires a request when the result queue has no room.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> (res_push && !res_full))
        else $error("request retired without result space");

endmodule
